FILE: rtl/vbpd_pkg.sv
// Package for the variance burst and plateau detector.
// Field widths, register indexes, reset values, state and operation codes.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package vbpd_pkg;

  localparam int AngleW  = 24;
  localparam int FrameW  = 32;
  localparam int VarW    = 48;
  localparam int SpreadW = 24;
  localparam int SumW    = 40;
  localparam int SqW     = 64;
  localparam int RunW    = 16;
  localparam int TolW    = 24;
  localparam int MulW    = 24;
  localparam int ProdW   = 2 * MulW;
  localparam int DivCntW = $clog2(SqW);
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 48;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM   = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_PLATEAU   = 4'd3;

  localparam logic [VarW-1:0] THRESHOLD_RST = 48'd429496730;
  localparam logic [RunW-1:0] CONFIRM_RST   = 16'd10;
  localparam logic [TolW-1:0] TOLERANCE_RST = 24'd3277;
  localparam logic [RunW-1:0] PLATEAU_RST   = 16'd30;

  localparam logic [VarW-1:0]  MIN_PREV = 48'd4294967;
  localparam logic [VarW-1:0]  VAR_MAX  = '1;
  localparam logic [RunW-1:0]  RUN_MAX  = '1;
  localparam logic [DivCntW-1:0] DIV_LAST = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_LOAD,
    ST_DIV,
    ST_MEAN2,
    ST_VAR,
    ST_MULH,
    ST_MULL,
    ST_DEC
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_SQ,
    OP_LOAD,
    OP_DIV,
    OP_MEAN2,
    OP_VAR,
    OP_MULH,
    OP_MULL,
    OP_DEC
  } op_e;

  typedef struct packed {
    logic restart;
    logic last;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/vbpd_ifs.sv
// Handshake channels of the detector: sample input, result output, register write.
// Depends on vbpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vbpd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vbpd_pkg::AngleW-1:0] angle;
  logic                               last_in_frame;
  logic [vbpd_pkg::FrameW-1:0]        frame_number;
  logic                               restart;

  modport source (output valid, angle, last_in_frame, frame_number, restart, input ready);
  modport sink   (input valid, angle, last_in_frame, frame_number, restart, output ready);
endinterface

interface vbpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [vbpd_pkg::VarW-1:0]     frame_variance;
  logic [vbpd_pkg::SpreadW-1:0]  spread;
  logic                          onset_found;
  logic [vbpd_pkg::FrameW-1:0]   onset_frame;
  logic [vbpd_pkg::VarW-1:0]     onset_variance;
  logic                          plateau_found;
  logic [vbpd_pkg::FrameW-1:0]   plateau_frame;
  logic [vbpd_pkg::VarW-1:0]     plateau_variance;

  modport source (output valid, frame_variance, spread, onset_found, onset_frame,
                  onset_variance, plateau_found, plateau_frame, plateau_variance,
                  input ready);
  modport sink   (input valid, frame_variance, spread, onset_found, onset_frame,
                  onset_variance, plateau_found, plateau_frame, plateau_variance,
                  output ready);
endinterface

interface vbpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vbpd_pkg::CfgIdxW-1:0]   index;
  logic [vbpd_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/vbpd_ctrl.sv
// Controller of the detector: sequences sample accumulation and frame-end math.
// Depends on vbpd_pkg; drives the datapath vbpd_dp by operation codes.
`timescale 1ns / 1ps
`default_nettype none

module vbpd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire vbpd_pkg::stat_t stat_i,
  output vbpd_pkg::op_e        op_o
);

  vbpd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vbpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = vbpd_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      vbpd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = vbpd_pkg::OP_TAKE;
          state_d = stat_i.restart ? vbpd_pkg::ST_IDLE : vbpd_pkg::ST_SQ;
        end
      end
      vbpd_pkg::ST_SQ: begin
        op_o    = vbpd_pkg::OP_SQ;
        state_d = stat_i.last ? vbpd_pkg::ST_LOAD : vbpd_pkg::ST_IDLE;
      end
      vbpd_pkg::ST_LOAD: begin
        op_o    = vbpd_pkg::OP_LOAD;
        state_d = vbpd_pkg::ST_DIV;
      end
      vbpd_pkg::ST_DIV: begin
        op_o = vbpd_pkg::OP_DIV;
        if (stat_i.div_done) begin
          state_d = vbpd_pkg::ST_MEAN2;
        end
      end
      vbpd_pkg::ST_MEAN2: begin
        op_o    = vbpd_pkg::OP_MEAN2;
        state_d = vbpd_pkg::ST_VAR;
      end
      vbpd_pkg::ST_VAR: begin
        op_o    = vbpd_pkg::OP_VAR;
        state_d = vbpd_pkg::ST_MULH;
      end
      vbpd_pkg::ST_MULH: begin
        op_o    = vbpd_pkg::OP_MULH;
        state_d = vbpd_pkg::ST_MULL;
      end
      vbpd_pkg::ST_MULL: begin
        op_o    = vbpd_pkg::OP_MULL;
        state_d = vbpd_pkg::ST_DEC;
      end
      vbpd_pkg::ST_DEC: begin
        if (stat_i.out_free) begin
          op_o    = vbpd_pkg::OP_DEC;
          state_d = vbpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vbpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/vbpd_dp.sv
// Datapath of the detector: accumulators, shared 24x24 multiplier, two
// one-bit-per-cycle dividers, onset and plateau state, registers, result word.
// Depends on vbpd_pkg; steered by vbpd_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module vbpd_dp #(
  parameter int MAX_SAMPLES = 65536
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire vbpd_pkg::op_e                       op_i,
  output vbpd_pkg::stat_t                          stat_o,
  input  wire logic signed [vbpd_pkg::AngleW-1:0]  angle_i,
  input  wire logic                                last_in_frame_i,
  input  wire logic [vbpd_pkg::FrameW-1:0]         frame_number_i,
  input  wire logic                                restart_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [vbpd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [vbpd_pkg::CfgDatW-1:0]        cfg_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [vbpd_pkg::VarW-1:0]                frame_variance_o,
  output logic [vbpd_pkg::SpreadW-1:0]             spread_o,
  output logic                                     onset_found_o,
  output logic [vbpd_pkg::FrameW-1:0]              onset_frame_o,
  output logic [vbpd_pkg::VarW-1:0]                onset_variance_o,
  output logic                                     plateau_found_o,
  output logic [vbpd_pkg::FrameW-1:0]              plateau_frame_o,
  output logic [vbpd_pkg::VarW-1:0]                plateau_variance_o
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);

  // configuration
  logic [vbpd_pkg::VarW-1:0] thr_q;
  logic [vbpd_pkg::RunW-1:0] conf_q;
  logic [vbpd_pkg::TolW-1:0] tol_q;
  logic [vbpd_pkg::RunW-1:0] pfr_q;

  // frame accumulators and detection state
  logic [CntW-1:0]                   cnt_q;
  logic signed [vbpd_pkg::SumW-1:0]  sum_q;
  logic [vbpd_pkg::SqW-1:0]          sq_q;
  logic signed [vbpd_pkg::AngleW-1:0] min_q, max_q;
  logic [vbpd_pkg::VarW-1:0]         prev_q;
  logic                              havep_q;
  logic [vbpd_pkg::RunW-1:0]         above_q, stable_q;
  logic                              oseen_q, pseen_q;
  logic [vbpd_pkg::FrameW-1:0]       ostart_q, pstart_q;
  logic [vbpd_pkg::VarW-1:0]         olvl_q, plvl_q;

  // working registers
  logic                              last_q, acc_en_q;
  logic [vbpd_pkg::FrameW-1:0]       frame_q;
  logic [vbpd_pkg::MulW-1:0]         a_mag_q;
  logic [CntW-1:0]                   n_q;
  logic [vbpd_pkg::SqW-1:0]          dq_q, dm_q;
  logic [CntW-1:0]                   rq_q, rm_q;
  logic [vbpd_pkg::DivCntW-1:0]      div_cnt_q;
  logic [vbpd_pkg::SpreadW-1:0]      spread_q;
  logic [vbpd_pkg::ProdW-1:0]        mul_q, ph_q;
  logic [vbpd_pkg::VarW-1:0]         var_q;
  logic [vbpd_pkg::SqW-1:0]          lhs_q;

  // combinational
  logic                              not_full;
  logic [vbpd_pkg::MulW-1:0]         in_mag;
  logic [vbpd_pkg::SumW-1:0]         sum_abs;
  logic [CntW-1:0]                   n_c;
  logic signed [vbpd_pkg::SpreadW:0] span;
  logic [vbpd_pkg::MulW-1:0]         mul_a, mul_b;
  logic [vbpd_pkg::ProdW-1:0]        mul_p;
  logic [vbpd_pkg::VarW-1:0]         pm;
  logic [vbpd_pkg::VarW-1:0]         dvar;
  logic [vbpd_pkg::SqW-1:0]          v64;
  logic [vbpd_pkg::VarW-1:0]         var_c;
  logic [CntW:0]                     tq, tm;
  logic [vbpd_pkg::ProdW+vbpd_pkg::TolW-1:0] bound;
  logic                              stable;
  logic [vbpd_pkg::RunW-1:0]         above_n, stable_n;
  logic [vbpd_pkg::VarW-1:0]         olvl_n;
  logic                              oseen_n, onow, pseen_n;
  logic [vbpd_pkg::FrameW-1:0]       ostart_n, pstart_n;
  logic [vbpd_pkg::VarW-1:0]         plvl_n;
  logic                              out_valid_q;

  assign not_full = cnt_q < CntMax;
  assign in_mag   = angle_i[vbpd_pkg::AngleW-1] ? (~angle_i + 1'b1) : angle_i;
  assign sum_abs  = sum_q[vbpd_pkg::SumW-1] ? vbpd_pkg::SumW'(-sum_q) : sum_q;
  assign n_c      = (cnt_q != '0) ? cnt_q : CntW'(1);
  assign span     = (vbpd_pkg::SpreadW+1)'(max_q) - (vbpd_pkg::SpreadW+1)'(min_q);
  assign pm       = (prev_q > vbpd_pkg::MIN_PREV) ? prev_q : vbpd_pkg::MIN_PREV;
  assign dvar     = (var_q > prev_q) ? (var_q - prev_q) : (prev_q - var_q);
  assign v64      = (dq_q > vbpd_pkg::SqW'(mul_q)) ? (dq_q - vbpd_pkg::SqW'(mul_q)) : '0;
  assign var_c    = (v64[vbpd_pkg::SqW-1:vbpd_pkg::VarW] != '0) ? vbpd_pkg::VAR_MAX
                                                               : v64[vbpd_pkg::VarW-1:0];
  assign tq       = {rq_q, dq_q[vbpd_pkg::SqW-1]};
  assign tm       = {rm_q, dm_q[vbpd_pkg::SqW-1]};
  assign bound    = {ph_q, vbpd_pkg::MulW'(0)} + (vbpd_pkg::ProdW+vbpd_pkg::TolW)'(mul_q);
  assign stable   = (tol_q != '0) &&
                    ((vbpd_pkg::ProdW+vbpd_pkg::TolW)'(lhs_q) < bound);

  always_comb begin
    case (op_i)
      vbpd_pkg::OP_MEAN2: begin
        mul_a = dm_q[vbpd_pkg::MulW-1:0];
        mul_b = dm_q[vbpd_pkg::MulW-1:0];
      end
      vbpd_pkg::OP_MULH: begin
        mul_a = pm[vbpd_pkg::VarW-1:vbpd_pkg::MulW];
        mul_b = tol_q;
      end
      vbpd_pkg::OP_MULL: begin
        mul_a = pm[vbpd_pkg::MulW-1:0];
        mul_b = tol_q;
      end
      default: begin
        mul_a = a_mag_q;
        mul_b = a_mag_q;
      end
    endcase
  end

  assign mul_p = vbpd_pkg::ProdW'(mul_a) * vbpd_pkg::ProdW'(mul_b);

  always_comb begin
    above_n  = above_q;
    olvl_n   = olvl_q;
    oseen_n  = oseen_q;
    ostart_n = ostart_q;
    onow     = 1'b0;
    stable_n = stable_q;
    pseen_n  = pseen_q;
    pstart_n = pstart_q;
    plvl_n   = plvl_q;
    if (!oseen_q) begin
      if (var_q > thr_q) begin
        if (above_q == '0) begin
          olvl_n = var_q;
        end
        if (above_q != vbpd_pkg::RUN_MAX) begin
          above_n = above_q + 1'b1;
        end
        if (above_n >= conf_q) begin
          oseen_n  = 1'b1;
          onow     = 1'b1;
          ostart_n = frame_q - vbpd_pkg::FrameW'(conf_q) + 1'b1;
        end
      end else begin
        above_n = '0;
        olvl_n  = '0;
      end
    end
    if (havep_q) begin
      if (stable) begin
        if (stable_q != vbpd_pkg::RUN_MAX) begin
          stable_n = stable_q + 1'b1;
        end
      end else begin
        stable_n = '0;
      end
    end
    if (oseen_n && !pseen_q && (stable_n >= pfr_q)) begin
      pseen_n  = 1'b1;
      pstart_n = frame_q - vbpd_pkg::FrameW'(pfr_q) + 1'b1;
      plvl_n   = var_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= vbpd_pkg::THRESHOLD_RST;
      conf_q <= vbpd_pkg::CONFIRM_RST;
      tol_q  <= vbpd_pkg::TOLERANCE_RST;
      pfr_q  <= vbpd_pkg::PLATEAU_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vbpd_pkg::CFG_THRESHOLD: thr_q  <= cfg_data_i[vbpd_pkg::VarW-1:0];
        vbpd_pkg::CFG_CONFIRM:   conf_q <= cfg_data_i[vbpd_pkg::RunW-1:0];
        vbpd_pkg::CFG_TOLERANCE: tol_q  <= cfg_data_i[vbpd_pkg::TolW-1:0];
        vbpd_pkg::CFG_PLATEAU:   pfr_q  <= cfg_data_i[vbpd_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      min_q    <= '0;
      max_q    <= '0;
      prev_q   <= '0;
      havep_q  <= 1'b0;
      above_q  <= '0;
      stable_q <= '0;
      oseen_q  <= 1'b0;
      ostart_q <= '0;
      olvl_q   <= '0;
      pseen_q  <= 1'b0;
      pstart_q <= '0;
      plvl_q   <= '0;
    end else begin
      case (op_i)
        vbpd_pkg::OP_TAKE: begin
          if (restart_i) begin
            cnt_q    <= '0;
            sum_q    <= '0;
            sq_q     <= '0;
            min_q    <= '0;
            max_q    <= '0;
            prev_q   <= '0;
            havep_q  <= 1'b0;
            above_q  <= '0;
            stable_q <= '0;
            oseen_q  <= 1'b0;
            ostart_q <= '0;
            olvl_q   <= '0;
            pseen_q  <= 1'b0;
            pstart_q <= '0;
            plvl_q   <= '0;
          end else if (not_full) begin
            if (cnt_q == '0) begin
              min_q <= angle_i;
              max_q <= angle_i;
            end else begin
              if (angle_i < min_q) min_q <= angle_i;
              if (angle_i > max_q) max_q <= angle_i;
            end
            sum_q <= sum_q + vbpd_pkg::SumW'(angle_i);
            cnt_q <= cnt_q + 1'b1;
          end
        end
        vbpd_pkg::OP_SQ: begin
          if (acc_en_q) begin
            sq_q <= sq_q + vbpd_pkg::SqW'(mul_p);
          end
        end
        vbpd_pkg::OP_LOAD: begin
          cnt_q <= '0;
          sum_q <= '0;
          sq_q  <= '0;
          min_q <= '0;
          max_q <= '0;
        end
        vbpd_pkg::OP_DEC: begin
          above_q  <= above_n;
          olvl_q   <= olvl_n;
          oseen_q  <= oseen_n;
          ostart_q <= ostart_n;
          stable_q <= stable_n;
          pseen_q  <= pseen_n;
          pstart_q <= pstart_n;
          plvl_q   <= plvl_n;
          prev_q   <= var_q;
          havep_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      vbpd_pkg::OP_TAKE: begin
        last_q   <= last_in_frame_i;
        frame_q  <= frame_number_i;
        a_mag_q  <= in_mag;
        acc_en_q <= !restart_i && not_full;
      end
      vbpd_pkg::OP_LOAD: begin
        n_q       <= n_c;
        dq_q      <= sq_q;
        dm_q      <= vbpd_pkg::SqW'(sum_abs) + vbpd_pkg::SqW'(n_c >> 1);
        rq_q      <= '0;
        rm_q      <= '0;
        div_cnt_q <= '0;
        spread_q  <= span[vbpd_pkg::SpreadW-1:0];
      end
      vbpd_pkg::OP_DIV: begin
        div_cnt_q <= div_cnt_q + 1'b1;
        if (tq >= {1'b0, n_q}) begin
          rq_q <= CntW'(tq - {1'b0, n_q});
          dq_q <= {dq_q[vbpd_pkg::SqW-2:0], 1'b1};
        end else begin
          rq_q <= tq[CntW-1:0];
          dq_q <= {dq_q[vbpd_pkg::SqW-2:0], 1'b0};
        end
        if (tm >= {1'b0, n_q}) begin
          rm_q <= CntW'(tm - {1'b0, n_q});
          dm_q <= {dm_q[vbpd_pkg::SqW-2:0], 1'b1};
        end else begin
          rm_q <= tm[CntW-1:0];
          dm_q <= {dm_q[vbpd_pkg::SqW-2:0], 1'b0};
        end
      end
      vbpd_pkg::OP_MEAN2: begin
        mul_q <= mul_p;
      end
      vbpd_pkg::OP_VAR: begin
        var_q <= var_c;
      end
      vbpd_pkg::OP_MULH: begin
        ph_q  <= mul_p;
        lhs_q <= {dvar, 16'b0};
      end
      vbpd_pkg::OP_MULL: begin
        mul_q <= mul_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == vbpd_pkg::OP_DEC) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == vbpd_pkg::OP_DEC) begin
      frame_variance_o   <= var_q;
      spread_o           <= spread_q;
      onset_found_o      <= onow;
      onset_frame_o      <= onow ? ostart_n : '0;
      onset_variance_o   <= onow ? olvl_n : '0;
      plateau_found_o    <= pseen_n;
      plateau_frame_o    <= pseen_n ? pstart_n : '0;
      plateau_variance_o <= pseen_n ? plvl_n : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.restart  = restart_i;
  assign stat_o.last     = last_q;
  assign stat_o.div_done = div_cnt_q == vbpd_pkg::DIV_LAST;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

FILE: rtl/variance_burst_plateau_detector_core.sv
// Top level of the variance burst and plateau detector.
// Depends on vbpd_pkg, vbpd_ifs (channels), vbpd_ctrl and vbpd_dp.
`timescale 1ns / 1ps
`default_nettype none

// Angle samples enter one word at a time on in_ch; each sample is captured,
// then squared and added through the shared 24x24 multiplier. The sample
// that closes a frame is captured, squared and loaded, then passes through 64
// steps of the pair of one-bit-per-cycle dividers (mean of squares and
// rounded mean), then five steps for the squared mean, the variance, the two
// halves of the tolerance product and the onset/plateau decision. The
// decision step waits while the output register still holds a result that
// has not been taken. A restart word clears the frame and onset/plateau
// history, keeping the registers. One result word per closing sample leaves
// on out_ch through an output register, so the next frame is accepted while
// a result waits. The register port is always ready.
module variance_burst_plateau_detector_core #(
  parameter int MAX_SAMPLES = 65536
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  vbpd_in_if.sink    in_ch,
  vbpd_out_if.source out_ch,
  vbpd_cfg_if.sink   cfg_ch
);

  vbpd_pkg::op_e   op;
  vbpd_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  vbpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  vbpd_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .stat_o             (stat),
    .angle_i            (in_ch.angle),
    .last_in_frame_i    (in_ch.last_in_frame),
    .frame_number_i     (in_ch.frame_number),
    .restart_i          (in_ch.restart),
    .cfg_we_i           (cfg_ch.valid),
    .cfg_index_i        (cfg_ch.index),
    .cfg_data_i         (cfg_ch.data),
    .out_valid_o        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .frame_variance_o   (out_ch.frame_variance),
    .spread_o           (out_ch.spread),
    .onset_found_o      (out_ch.onset_found),
    .onset_frame_o      (out_ch.onset_frame),
    .onset_variance_o   (out_ch.onset_variance),
    .plateau_found_o    (out_ch.plateau_found),
    .plateau_frame_o    (out_ch.plateau_frame),
    .plateau_variance_o (out_ch.plateau_variance)
  );

endmodule

`default_nettype wire

FILE: tb/variance_burst_plateau_detector_core_test.sv
// Testbench for variance_burst_plateau_detector_core: directed and random angle frames,
// random handshake gaps and long output stalls, each result checked against a bench model.
// Depends on vbpd_pkg, vbpd_ifs and the core RTL.
`timescale 1ns / 1ps

module variance_burst_plateau_detector_core_test;
  import vbpd_pkg::*;

  localparam int MAX_SAMPLES  = 65536;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 700;
  localparam int ANGLE_MAX    = 8388607;
  localparam int ANGLE_MIN    = -8388608;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 220;

  typedef struct packed {
    logic [VarW-1:0]    frame_variance;
    logic [SpreadW-1:0] spread;
    logic               onset_found;
    logic [FrameW-1:0]  onset_frame;
    logic [VarW-1:0]    onset_variance;
    logic               plateau_found;
    logic [FrameW-1:0]  plateau_frame;
    logic [VarW-1:0]    plateau_variance;
  } frame_result_t;

  class frame_variance_tracker;
    logic [VarW-1:0]   threshold;
    logic [RunW-1:0]   confirm_n;
    logic [TolW-1:0]   tolerance;
    logic [RunW-1:0]   plateau_n;

    int unsigned       count;
    longint            angle_sum;
    logic [63:0]       square_sum;
    longint            angle_lo, angle_hi;
    logic [VarW-1:0]   prev_var;
    bit                have_prev;
    logic [RunW-1:0]   above_run, stable_run;
    bit                onset_seen, plateau_seen;
    logic [FrameW-1:0] onset_start, plateau_start;
    logic [VarW-1:0]   onset_level, plateau_level;

    frame_result_t     pending_frames[$];
    int                errors;

    function new();
      threshold = THRESHOLD_RST;
      confirm_n = CONFIRM_RST;
      tolerance = TOLERANCE_RST;
      plateau_n = PLATEAU_RST;
      errors = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      angle_sum = 0;
      square_sum = '0;
      angle_lo = 0;
      angle_hi = 0;
      prev_var = '0;
      have_prev = 0;
      above_run = '0;
      stable_run = '0;
      onset_seen = 0;
      onset_start = '0;
      onset_level = '0;
      plateau_seen = 0;
      plateau_start = '0;
      plateau_level = '0;
    endfunction

    function void set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
      case (idx)
        CFG_THRESHOLD: threshold = value[VarW-1:0];
        CFG_CONFIRM:   confirm_n = value[RunW-1:0];
        CFG_TOLERANCE: tolerance = value[TolW-1:0];
        CFG_PLATEAU:   plateau_n = value[RunW-1:0];
        default: ;
      endcase
    endfunction

    function logic [VarW-1:0] current_variance();
      logic [63:0] n, mag, mean, msq, m2, v;
      n = (count == 0) ? 64'd1 : 64'(count);
      mag = (angle_sum < 0) ? 64'(-angle_sum) : 64'(angle_sum);
      mean = (mag + n / 2) / n;
      msq = square_sum / n;
      m2 = mean * mean;
      v = (msq > m2) ? msq - m2 : 64'd0;
      return (v > 64'(VAR_MAX)) ? VAR_MAX : v[VarW-1:0];
    endfunction

    function bit stable_change(input logic [63:0] prev, input logic [63:0] cur);
      logic [63:0] d, lhs, pm, tol;
      tol = 64'(tolerance);
      d = (cur > prev) ? cur - prev : prev - cur;
      lhs = d << 16;
      pm = (prev > 64'(MIN_PREV)) ? prev : 64'(MIN_PREV);
      if (tol == 0) return 0;
      if (pm > 64'hFFFF_FFFF_FFFF_FFFF / tol) return 1;
      return lhs < tol * pm;
    endfunction

    function void take_word(input int angle, input bit last, input logic [FrameW-1:0] frame,
                            input bit restart);
      logic signed [AngleW-1:0] a24;
      longint sample;
      logic [VarW-1:0] v;
      bit onset_now;
      frame_result_t r;
      if (restart) begin
        clear();
        return;
      end
      a24 = angle[AngleW-1:0];
      sample = a24;
      if (count < MAX_SAMPLES) begin
        if (count == 0) begin
          angle_lo = sample;
          angle_hi = sample;
        end else begin
          if (sample < angle_lo) angle_lo = sample;
          if (sample > angle_hi) angle_hi = sample;
        end
        angle_sum += sample;
        square_sum += 64'(sample * sample);
        count++;
      end
      if (!last) return;

      v = current_variance();
      onset_now = 0;
      if (!onset_seen) begin
        if (v > threshold) begin
          if (above_run == 0) onset_level = v;
          if (above_run != RUN_MAX) above_run++;
          if (above_run >= confirm_n) begin
            onset_seen = 1;
            onset_now = 1;
            onset_start = frame - FrameW'(confirm_n) + 1;
          end
        end else begin
          above_run = '0;
          onset_level = '0;
        end
      end

      if (have_prev) begin
        if (stable_change(64'(prev_var), 64'(v))) begin
          if (stable_run != RUN_MAX) stable_run++;
        end else begin
          stable_run = '0;
        end
      end
      prev_var = v;
      have_prev = 1;

      if (onset_seen && !plateau_seen && stable_run >= plateau_n) begin
        plateau_seen = 1;
        plateau_start = frame - FrameW'(plateau_n) + 1;
        plateau_level = v;
      end

      r.frame_variance = v;
      r.spread = SpreadW'(angle_hi - angle_lo);
      r.onset_found = onset_now;
      r.onset_frame = onset_now ? onset_start : '0;
      r.onset_variance = onset_now ? onset_level : '0;
      r.plateau_found = plateau_seen;
      r.plateau_frame = plateau_seen ? plateau_start : '0;
      r.plateau_variance = plateau_seen ? plateau_level : '0;
      pending_frames = {pending_frames, r};

      count = 0;
      angle_sum = 0;
      square_sum = '0;
      angle_lo = 0;
      angle_hi = 0;
    endfunction

    function void compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
        errors++;
      end
    endfunction

    function void match_frame(input frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t unexpected result: variance %0h spread %0h", $time,
                 got.frame_variance, got.spread);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      compare_field("frame_variance", 64'(want.frame_variance), 64'(got.frame_variance));
      compare_field("spread", 64'(want.spread), 64'(got.spread));
      compare_field("onset_found", 64'(want.onset_found), 64'(got.onset_found));
      compare_field("onset_frame", 64'(want.onset_frame), 64'(got.onset_frame));
      compare_field("onset_variance", 64'(want.onset_variance), 64'(got.onset_variance));
      compare_field("plateau_found", 64'(want.plateau_found), 64'(got.plateau_found));
      compare_field("plateau_frame", 64'(want.plateau_frame), 64'(got.plateau_frame));
      compare_field("plateau_variance", 64'(want.plateau_variance),
                    64'(got.plateau_variance));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vbpd_in_if  in_ch();
  vbpd_out_if out_ch();
  vbpd_cfg_if cfg_ch();

  variance_burst_plateau_detector_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  frame_variance_tracker sb = new();

  bit                src_idle = 1;
  bit                snk_idle = 1;
  int unsigned       words_sent = 0;
  int                idle_cycles = 0;
  logic [FrameW-1:0] frame_no = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_word(input int angle, input bit last, input logic [FrameW-1:0] frame,
                           input bit restart);
    int unsigned gap;
    gap = src_idle ? $urandom_range(12, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.angle <= angle[AngleW-1:0];
    in_ch.last_in_frame <= last;
    in_ch.frame_number <= frame;
    in_ch.restart <= restart;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    sb.take_word(angle, last, frame, restart);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_restart();
    send_word(int'($urandom_range(ANGLE_MAX - ANGLE_MIN, 0)) + ANGLE_MIN,
              1'($urandom_range(1, 0)), $urandom, 1'b1);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    sb.set_register(idx, value);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [VarW-1:0] thr, input logic [RunW-1:0] conf,
                           input logic [TolW-1:0] tol, input logic [RunW-1:0] plat);
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_CONFIRM, conf);
    write_register(CFG_TOLERANCE, tol);
    write_register(CFG_PLATEAU, plat);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Alternate samples around a random center so the variance tracks amp squared; with noise set, samples are random.
  task automatic send_frame(input int amp, input int jit, input int len, input bit noise);
    int room, center, a, k;
    room = ANGLE_MAX - amp - jit;
    center = int'($urandom_range(2 * room, 0)) - room;
    for (k = 0; k < len; k++) begin
      if (noise) a = int'($urandom_range(ANGLE_MAX - ANGLE_MIN, 0)) + ANGLE_MIN;
      else a = center + ((k % 2) ? amp : -amp) + int'($urandom_range(2 * jit, 0)) - jit;
      if ($urandom_range(99, 0) == 0) send_restart();
      send_word(a, k == len - 1, (k == len - 1) ? frame_no : $urandom, 1'b0);
    end
    frame_no++;
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned start;
    int amp, jit, len, run, k;
    bit fixed_len;
    start = words_sent;
    while (words_sent - start < quota) begin
      if ($urandom_range(3, 0) == 0) send_restart();
      amp = int'($urandom_range(ANGLE_MAX / 2, 0)) >> $urandom_range(22, 0);
      jit = ($urandom_range(7, 0) == 0) ? amp / 2 : amp >> $urandom_range(12, 4);
      run = $urandom_range(12, 1);
      len = $urandom_range(4, 1);
      fixed_len = $urandom_range(3, 0) != 0;
      for (k = 0; k < run; k++) begin
        send_frame(amp, jit, fixed_len ? len : int'($urandom_range(6, 1)),
                   $urandom_range(9, 0) == 0);
      end
    end
  endtask

  initial begin : sink_side
    int unsigned gap, taken;
    taken = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 40 || taken == 300) gap = HOLD_CYCLES;
      else gap = snk_idle ? $urandom_range(12, 0) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.frame_variance = out_ch.frame_variance;
      got.spread = out_ch.spread;
      got.onset_found = out_ch.onset_found;
      got.onset_frame = out_ch.onset_frame;
      got.onset_variance = out_ch.onset_variance;
      got.plateau_found = out_ch.plateau_found;
      got.plateau_frame = out_ch.plateau_frame;
      got.plateau_variance = out_ch.plateau_variance;
      sb.match_frame(got);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("variance_burst_plateau_detector_core_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    logic [VarW-1:0] thr;
    logic [RunW-1:0] conf, plat;
    logic [TolW-1:0] tol;
    in_ch.valid = 1'b0;
    in_ch.angle = '0;
    in_ch.last_in_frame = 1'b0;
    in_ch.frame_number = '0;
    in_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset register values: extremes of the angle and frame fields.
    send_word(0, 1'b1, 32'd0, 1'b0);
    send_word(ANGLE_MIN, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_word(ANGLE_MAX, 1'b1, 32'd1, 1'b0);
    send_word(ANGLE_MIN, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_word(ANGLE_MAX, 1'b0, 32'd3, 1'b0);
    send_word(ANGLE_MAX, 1'b0, 32'd3, 1'b0);
    send_word(ANGLE_MAX, 1'b1, 32'd3, 1'b0);
    send_word(ANGLE_MIN, 1'b0, 32'd4, 1'b0);
    send_word(ANGLE_MIN + 1, 1'b1, 32'd4, 1'b0);
    // Restart in mid-frame drops the partial frame.
    send_word(100, 1'b0, 32'd5, 1'b0);
    send_word(-5, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_word(7, 1'b0, 32'd6, 1'b0);
    send_word(-9, 1'b1, 32'd6, 1'b0);
    settle();

    // Zero confirm and plateau lengths, widest tolerance.
    configure('0, '0, '1, '0);
    send_word(-1000, 1'b0, 32'd10, 1'b0);
    send_word(1000, 1'b1, 32'd10, 1'b0);
    send_word(-1000, 1'b0, 32'd11, 1'b0);
    send_word(1000, 1'b1, 32'd11, 1'b0);
    send_word(42, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_restart();
    send_word(-3, 1'b0, 32'd13, 1'b0);
    send_word(3, 1'b1, 32'd13, 1'b0);
    settle();

    // Zero tolerance, unreachable threshold.
    configure(VAR_MAX, RUN_MAX, '0, RUN_MAX);
    send_word(-1000, 1'b0, 32'd20, 1'b0);
    send_word(1000, 1'b1, 32'd20, 1'b0);
    send_word(-1000, 1'b0, 32'd21, 1'b0);
    send_word(1000, 1'b1, 32'd21, 1'b0);
    send_restart();
    settle();

    for (p = 0; p < PHASES; p++) begin
      thr = VarW'({$urandom, $urandom} >> $urandom_range(60, 20));
      conf = RunW'($urandom_range(6, 1));
      tol = TolW'($urandom_range(8000, 500));
      plat = RunW'($urandom_range(8, 1));
      if (p == 3) thr = VAR_MAX;
      if (p == 6) thr = '0;
      if (p == 4) conf = '0;
      if (p == 7) conf = RUN_MAX;
      if (p == 2) tol = '0;
      if (p == 5) tol = '1;
      if (p == 6) tol = TolW'($urandom);
      if (p == 4) plat = '0;
      if (p == 1) plat = RUN_MAX;
      frame_no = (p == 5) ? 32'hFFFF_FFF8 : $urandom;
      src_idle = (p % 3) != 2;
      snk_idle = (p % 4) != 3;
      configure(thr, conf, tol, plat);
      random_traffic(PHASE_WORDS);
      settle();
    end

    if (sb.errors == 0) $display("variance_burst_plateau_detector_core_test: done, clean");
    else $display("variance_burst_plateau_detector_core_test: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/vbpd_pkg.sv
rtl/vbpd_ifs.sv
rtl/vbpd_ctrl.sv
rtl/vbpd_dp.sv
rtl/variance_burst_plateau_detector_core.sv
tb/variance_burst_plateau_detector_core_test.sv
